// ===== hdl/ovl_pkg.sv =====
// shared types, constants and helpers for the ordered value list core
// no dependencies; imported by every module of the block

package ovl_pkg;

    // list geometry
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int POS_W      = 5;
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // operation codes
    localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [3:0] OP_INSERT_AT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_POP_FRONT  = 4'd4;
    localparam logic [3:0] OP_REMOVE_AT  = 4'd5;
    localparam logic [3:0] OP_CONTAINS   = 4'd6;
    localparam logic [3:0] OP_GET_AT     = 4'd7;
    localparam logic [3:0] OP_INDEX_OF   = 4'd8;
    localparam logic [3:0] OP_LENGTH     = 4'd9;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic signed [31:0] FAIL_VALUE = -32'sd1;

    // one request item
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } ovl_in_t;

    // one result item
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               found;
        logic [2:0]         status;
        logic [4:0]         count_after;
    } ovl_out_t;

    typedef logic [VALUE_BITS-1:0] slot_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND
    } ovl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic find;
    } ovl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_op;
    } ovl_stat_t;

    // input value to stored width (sign-extend or truncate)
    function automatic slot_t to_slot(input logic signed [31:0] v);
        logic signed [VALUE_BITS-1:0] s;
        s = VALUE_BITS'(v);
        return slot_t'(s);
    endfunction

    // stored value back to the 32-bit result field
    function automatic logic signed [31:0] to_result(input slot_t v);
        logic signed [VALUE_BITS-1:0] s;
        s = signed'(v);
        return 32'(s);
    endfunction

endpackage

// ===== hdl/ordered_value_list_core.sv =====
// ordered value list core: after start is taken an execute step registers the
// result; contains and index of on a non-empty list register the compares and
// add a first-match step; busy is high until the result is registered;
// the strobe cycle overlaps the next start, and the receiver cannot stall
// reset clears the count and the strobe; slot contents are not reset
// depends on ovl_pkg, ovl_ctrl and ovl_datapath

module ordered_value_list_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ovl_pkg::ovl_in_t  request,
    output ovl_pkg::ovl_out_t response,
    output logic              done
);
    import ovl_pkg::*;

    ovl_cmd_t  cmd;
    ovl_stat_t stat;

    // sequencer
    ovl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // list storage and operations
    ovl_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .stat     (stat),
        .response (response),
        .done     (done)
    );

    // every result follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a pending item");

    // a failed item answers the fail value and no found flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status != ST_OK)) |->
        ((response.result_value == FAIL_VALUE) && !response.found))
        else $error("failed item with wrong result value");

    // reported count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.count_after <= 5'(CAPACITY)))
        else $error("reported count beyond capacity");

endmodule

// ===== hdl/ovl_ctrl.sv =====
// controller state machine for the ordered value list core
// depends on ovl_pkg for the state enum and command/status structs

module ovl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ovl_pkg::ovl_stat_t stat,
    output ovl_pkg::ovl_cmd_t  cmd,
    output logic              busy
);
    import ovl_pkg::*;

    ovl_state_t state_reg;
    ovl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.search_op ? S_FIND : S_IDLE;
            end
            S_FIND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // a search only follows an execute step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> $past(state_reg == S_EXEC))
        else $error("find step without execute step");

    // an accepted item always moves into execute
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("accepted item did not start execution");

    // the controller is never idle in the cycle after execute unless no search
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.search_op) |=> cmd.find)
        else $error("search op skipped the find step");

endmodule

// ===== hdl/ovl_datapath.sv =====
// slot cell chain, count register, decode, search and result register
// depends on ovl_pkg for geometry, codes, structs and value conversions

module ovl_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ovl_pkg::ovl_cmd_t  cmd,
    input  ovl_pkg::ovl_in_t   request,
    output ovl_pkg::ovl_stat_t stat,
    output ovl_pkg::ovl_out_t  response,
    output logic               done
);
    import ovl_pkg::*;

    ovl_in_t              req_reg;
    slot_t                slots_reg [CAPACITY];
    slot_t                slots_next [CAPACITY];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CAPACITY-1:0]  match_reg;
    logic [CAPACITY-1:0]  match_next;
    ovl_out_t             resp_reg;
    logic                 done_reg;

    slot_t                val_slot;
    slot_t                rd_data;
    logic [CNT_W-1:0]     rd_sel;
    logic [CNT_W-1:0]     put_idx;
    logic [CNT_W-1:0]     pos_idx;
    logic [CMP_W-1:0]     pos_w;
    logic [CMP_W-1:0]     cnt_w;
    logic                 full;
    logic                 empty;
    logic                 ins_ok;
    logic                 rd_ok;
    logic                 do_put;
    logic                 do_take;
    ovl_out_t             exec_resp;
    ovl_out_t             find_resp;
    logic [IDX_W-1:0]     first_idx;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    // common decode terms
    assign val_slot = to_slot(req_reg.value);
    assign full     = count_reg >= CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;
    assign pos_w    = CMP_W'(req_reg.position);
    assign cnt_w    = CMP_W'(count_reg);
    assign ins_ok   = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    assign rd_ok    = (pos_w != '0) && (pos_w <= cnt_w);
    assign pos_idx  = CNT_W'(pos_w - CMP_W'(1));

    assign stat.search_op = ((req_reg.op == OP_CONTAINS) || (req_reg.op == OP_INDEX_OF))
                            && !empty;

    // single read port into the chain
    always_comb
    begin
        if (req_reg.op == OP_POP_BACK)
        begin
            rd_sel = count_reg - CNT_W'(1);
        end
        else if (req_reg.op == OP_POP_FRONT)
        begin
            rd_sel = '0;
        end
        else
        begin
            rd_sel = pos_idx;
        end
    end

    assign rd_data = slots_reg[rd_sel[IDX_W-1:0]];

    // op decode, count update and result for non-search ops
    always_comb
    begin
        do_put                 = 1'b0;
        do_take                = 1'b0;
        put_idx                = count_reg;
        exec_resp.result_value = FAIL_VALUE;
        exec_resp.found        = 1'b0;
        exec_resp.status       = ST_RANGE;
        unique case (req_reg.op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT:
            begin
                if (full)
                begin
                    exec_resp.status = ST_FULL;
                end
                else if ((req_reg.op == OP_INSERT_AT) && !ins_ok)
                begin
                    exec_resp.status = ST_RANGE;
                end
                else
                begin
                    do_put = 1'b1;
                    if (req_reg.op == OP_PUSH_FRONT)
                    begin
                        put_idx = '0;
                    end
                    else if (req_reg.op == OP_INSERT_AT)
                    begin
                        put_idx = pos_idx;
                    end
                    exec_resp.result_value = to_result(val_slot);
                    exec_resp.status       = ST_OK;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (empty)
                begin
                    exec_resp.status = ST_EMPTY;
                end
                else
                begin
                    do_take                = 1'b1;
                    exec_resp.result_value = to_result(rd_data);
                    exec_resp.status       = ST_OK;
                end
            end
            OP_REMOVE_AT, OP_GET_AT:
            begin
                if (empty)
                begin
                    exec_resp.status = ST_EMPTY;
                end
                else if (!rd_ok)
                begin
                    exec_resp.status = ST_RANGE;
                end
                else
                begin
                    do_take                = (req_reg.op == OP_REMOVE_AT);
                    exec_resp.result_value = to_result(rd_data);
                    exec_resp.status       = ST_OK;
                end
            end
            OP_CONTAINS, OP_INDEX_OF:
            begin
                // only the empty case finishes here
                exec_resp.status = ST_EMPTY;
            end
            OP_LENGTH:
            begin
                exec_resp.result_value = 32'(count_reg);
                exec_resp.status       = ST_OK;
            end
            default:
            begin
                exec_resp.status = ST_RANGE;
            end
        endcase

        // count update
        count_next = count_reg;
        if (do_put)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_take)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        exec_resp.count_after = 5'(count_next);
    end

    // each cell picks itself, its neighbor below or above, or the new value
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slots_next[i] = slots_reg[i];
            if (do_put)
            begin
                if (CNT_W'(i) == put_idx)
                begin
                    slots_next[i] = val_slot;
                end
                else if (CNT_W'(i) > put_idx)
                begin
                    slots_next[i] = slots_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (do_take)
            begin
                if ((CNT_W'(i) >= rd_sel) && (i < CAPACITY - 1))
                begin
                    slots_next[i] = slots_reg[(i == CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    // per-cell compare against the search value
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_next[i] = (slots_reg[i] == val_slot) && (CNT_W'(i) < count_reg);
        end
    end

    // first match, lowest cell wins
    always_comb
    begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end

    // search result
    always_comb
    begin
        find_resp.count_after = 5'(count_reg);
        if (|match_reg)
        begin
            find_resp.found  = 1'b1;
            find_resp.status = ST_OK;
            if (req_reg.op == OP_CONTAINS)
            begin
                find_resp.result_value = 32'sd1;
            end
            else
            begin
                find_resp.result_value = signed'(32'(first_idx) + 32'd1);
            end
        end
        else
        begin
            find_resp.found        = 1'b0;
            find_resp.status       = ST_NOTFOUND;
            find_resp.result_value = FAIL_VALUE;
        end
    end

    // cell chain and match vector
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slots_reg[i] <= slots_next[i];
            end
            match_reg <= match_next;
        end
    end

    // count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec && !stat.search_op)
        begin
            resp_reg <= exec_resp;
        end
        else if (cmd.find)
        begin
            resp_reg <= find_resp;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.exec && !stat.search_op) || cmd.find;
        end
    end

    assign response = resp_reg;
    assign done     = done_reg;

    // count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    // count moves by at most one per item and only on execute
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.exec) |-> $stable(count_reg))
        else $error("count changed outside execute");

    // a search op leaves the list untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.search_op) |=> $stable(count_reg))
        else $error("search op changed the count");

endmodule
